// ----- rtl/dbd_pkg.sv -----
package dbd_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int CountW = 22;
	localparam int SerialW = 23;
	localparam int StepW  = 4;
	localparam int MulAW  = 14;
	localparam int MulBW  = 13;
	localparam int ProdW  = MulAW + MulBW;
	localparam int QuoW   = 8;
	localparam int RecipShift = 19;
	localparam int InDataW  = 48;
	localparam int OutDataW = 24;

	localparam logic [MulBW-1:0] DaysPerYear = MulBW'(365);
	localparam logic [MulBW-1:0] Recip100    = MulBW'(5243);
	localparam logic [MulBW-1:0] Hundred     = MulBW'(100);

	typedef logic [StepW-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL,
		OP_QSET,
		OP_LEAP,
		OP_ACC_YEAR,
		OP_SUB_Q,
		OP_ADD_Q,
		OP_MONTH,
		OP_SAVE,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		MA_Y,
		MA_P,
		MA_P4,
		MA_Q
	} mula_t;

	typedef enum logic [1:0] {
		MB_365,
		MB_RECIP,
		MB_100
	} mulb_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_YEAR_ZERO,
		JC_END_SEL
	} cond_t;

	typedef struct packed {
		op_t   op;
		mula_t mul_a;
		mulb_t mul_b;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic  load;
		logic  run;
		ctrl_t word;
	} seq_ctl_t;

	typedef struct packed {
		logic year_zero;
		logic end_sel;
		logic out_free;
	} dp_stat_t;

	localparam step_t StepMonth = StepW'(11);
	localparam step_t StepDone  = StepW'(13);
	localparam step_t StepLoad  = StepW'(0);

	// Microprogram: run once for the start date, once for the end date.
	function automatic ctrl_t rom_word(input step_t step);
		ctrl_t w;
		w = '{op: OP_NOP, mul_a: MA_Y, mul_b: MB_365, cond: JC_NONE, target: StepLoad};
		case (step)
			4'd0:  w.op = OP_LOAD;
			4'd1:  begin w.op = OP_MUL; w.mul_a = MA_Y;  w.mul_b = MB_RECIP; end
			4'd2:  w.op = OP_QSET;
			4'd3:  begin w.op = OP_MUL; w.mul_a = MA_Q;  w.mul_b = MB_100; end
			4'd4:  begin w.op = OP_LEAP; w.cond = JC_YEAR_ZERO; w.target = StepMonth; end
			4'd5:  begin w.op = OP_MUL; w.mul_a = MA_Y;  w.mul_b = MB_365; end
			4'd6:  w.op = OP_ACC_YEAR;
			4'd7:  begin w.op = OP_MUL; w.mul_a = MA_P;  w.mul_b = MB_RECIP; end
			4'd8:  w.op = OP_SUB_Q;
			4'd9:  begin w.op = OP_MUL; w.mul_a = MA_P4; w.mul_b = MB_RECIP; end
			4'd10: w.op = OP_ADD_Q;
			4'd11: begin w.op = OP_MONTH; w.cond = JC_END_SEL; w.target = StepDone; end
			4'd12: begin w.op = OP_SAVE; w.cond = JC_ALWAYS; w.target = StepLoad; end
			default: w.op = OP_DONE;
		endcase
		return w;
	endfunction

	// Days in months before month m of a common year; months past 12 add 31, 30 and 31 days in turn.
	function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
		logic [8:0] r;
		case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			4'd13: r = 9'd365;
			4'd14: r = 9'd395;
			default: r = 9'd426;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/days_between_dates_unit.sv -----
// Channel  | Beat fields (tdata, lowest bit up)
// s_axis   | start_day[4:0] start_month[8:5] start_year[22:9]
//          | end_day[27:23] end_month[31:28] end_year[45:32], zero [47:46]
// m_axis   | day_count[21:0] order_error[22], zero [23]
//
// Each date runs through the microprogram on one shared 14x13 multiplier: 13 steps
// for the start date and 12 for the end date, 6 fewer for a date in year 0; then the
// done step loads the result and raises m_axis_tvalid. The sequencer takes one item
// at a time; s_axis_tready is high while it is idle, so the next beat can be accepted
// in the cycle after the result loads.
// The result sits in an output register, so the next beat is accepted while
// m_axis stalls; a finished item waits in its last step until that register frees.
// arst_n clears the sequencer and the output valid flag.
module days_between_dates_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dbd_pkg::InDataW-1:0]         s_axis_tdata,  // start d,m,y then end d,m,y
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dbd_pkg::OutDataW-1:0]        m_axis_tdata   // day_count, order_error
);
	import dbd_pkg::*;

	seq_ctl_t          ctl;
	dp_stat_t          stat;
	logic              idle;
	logic              start;
	logic [CountW-1:0] day_count;
	logic              order_error;

	assign s_axis_tready = idle;
	assign start = s_axis_tvalid && idle;

	dbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.idle   (idle),
		.ctl    (ctl)
	);

	dbd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.in_data     (s_axis_tdata),
		.out_ready   (m_axis_tready),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.day_count   (day_count),
		.order_error (order_error)
	);

	assign m_axis_tdata = {1'b0, order_error, day_count};

endmodule

// ----- rtl/dbd_seq.sv -----
module dbd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dbd_pkg::dp_stat_t  stat,
	output logic               idle,
	output dbd_pkg::seq_ctl_t  ctl
);
	import dbd_pkg::*;

	logic  busy_q;
	step_t step_q;
	ctrl_t word;
	logic  take_jump;

	assign word = rom_word(step_q);
	assign idle = !busy_q;

	always_comb begin
		case (word.cond)
			JC_ALWAYS:    take_jump = 1'b1;
			JC_YEAR_ZERO: take_jump = stat.year_zero;
			JC_END_SEL:   take_jump = stat.end_sel;
			default:      take_jump = 1'b0;
		endcase
	end

	always_comb begin
		ctl.load = start;
		ctl.run  = busy_q;
		ctl.word = word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= StepLoad;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepLoad;
			end
		end else if (word.op == OP_DONE) begin
			// hold here until the output register can take the result
			if (stat.out_free) begin
				busy_q <= 1'b0;
			end
		end else if (take_jump) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + StepW'(1);
		end
	end

endmodule

// ----- rtl/dbd_dp.sv -----
module dbd_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dbd_pkg::seq_ctl_t              ctl,
	input  logic [dbd_pkg::InDataW-1:0]    in_data,
	input  logic                           out_ready,
	output dbd_pkg::dp_stat_t              stat,
	output logic                           out_valid,
	output logic [dbd_pkg::CountW-1:0]     day_count,
	output logic                           order_error
);
	import dbd_pkg::*;

	logic [DayW-1:0]    sd_q, ed_q;
	logic [MonthW-1:0]  sm_q, em_q;
	logic [YearW-1:0]   sy_q, ey_q;
	logic               sel_q;
	logic [YearW-1:0]   y_q;
	logic [QuoW-1:0]    q_q;
	logic               leap_q;
	logic [ProdW-1:0]   prod_q;
	logic [SerialW-1:0] acc_q, start_q;
	logic               out_valid_q;
	logic [CountW-1:0]  count_q;
	logic               err_q;

	logic [YearW-1:0]   p;
	logic [MulAW-1:0]   mul_a;
	logic [MulBW-1:0]   mul_b;
	logic [QuoW-1:0]    quo;
	logic [DayW-1:0]    cur_d;
	logic [MonthW-1:0]  cur_m;
	logic               month_leap;
	logic [SerialW-1:0] diff;
	logic               out_free;
	logic               run_done;

	assign p     = y_q - YearW'(1);
	assign quo   = prod_q[RecipShift +: QuoW];
	assign cur_d = sel_q ? ed_q : sd_q;
	assign cur_m = sel_q ? em_q : sm_q;
	assign month_leap = leap_q && (cur_m > MonthW'(2));
	assign diff  = acc_q - start_q;
	assign out_free = !out_valid_q || out_ready;
	assign run_done = ctl.run && (ctl.word.op == OP_DONE) && out_free;

	always_comb begin
		case (ctl.word.mul_a)
			MA_P:    mul_a = p;
			MA_P4:   mul_a = MulAW'(p >> 2);
			MA_Q:    mul_a = MulAW'(q_q);
			default: mul_a = y_q;
		endcase
		case (ctl.word.mul_b)
			MB_RECIP: mul_b = Recip100;
			MB_100:   mul_b = Hundred;
			default:  mul_b = DaysPerYear;
		endcase
	end

	always_comb begin
		stat.year_zero = (y_q == '0);
		stat.end_sel   = sel_q;
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sd_q <= in_data[4:0];
			sm_q <= in_data[8:5];
			sy_q <= in_data[22:9];
			ed_q <= in_data[27:23];
			em_q <= in_data[31:28];
			ey_q <= in_data[45:32];
			sel_q <= 1'b0;
		end else if (ctl.run) begin
			case (ctl.word.op)
				OP_LOAD: begin
					y_q   <= sel_q ? ey_q : sy_q;
					acc_q <= '0;
				end
				OP_MUL:  prod_q <= mul_a * mul_b;
				OP_QSET: q_q <= quo;
				OP_LEAP: begin
					// divisible by 4, and not by 100 unless by 400
					leap_q <= (y_q[1:0] == 2'b00) &&
						((prod_q != ProdW'(y_q)) || (q_q[1:0] == 2'b00));
				end
				OP_ACC_YEAR: acc_q <= SerialW'(prod_q) + SerialW'(p >> 2) + SerialW'(1);
				OP_SUB_Q:    acc_q <= acc_q - SerialW'(quo);
				OP_ADD_Q:    acc_q <= acc_q + SerialW'(quo);
				OP_MONTH: begin
					acc_q <= acc_q + SerialW'(month_offset(cur_m)) +
						SerialW'(month_leap) + SerialW'(cur_d);
				end
				OP_SAVE: begin
					start_q <= acc_q;
					sel_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_done) begin
			if (acc_q < start_q) begin
				count_q <= '0;
				err_q   <= 1'b1;
			end else begin
				// saturate at the top of the count field
				count_q <= diff[SerialW-1] ? '1 : diff[CountW-1:0];
				err_q   <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign day_count   = count_q;
	assign order_error = err_q;

endmodule
